// ----- src/spos_pkg.sv -----
package spos_pkg;

    localparam int POS_W  = 17;
    localparam int STEP_W = 16;
    localparam int CNT_W  = 16;
    localparam int DIR_W  = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;
    localparam logic signed [POS_W-1:0] AZ_MIN_RESET  = -17'sd18000;
    localparam logic signed [POS_W-1:0] AZ_MAX_RESET  = 17'sd18000;
    localparam logic signed [POS_W-1:0] EL_MIN_RESET  = -17'sd9000;
    localparam logic signed [POS_W-1:0] EL_MAX_RESET  = 17'sd9000;
    localparam logic signed [POS_W-1:0] POL_MIN_LIMIT = -17'sd18000;
    localparam logic signed [POS_W-1:0] POL_MAX_LIMIT = 17'sd18000;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [2:0] REG_STEP_AZ  = 3'd0;
    localparam logic [2:0] REG_STEP_EL  = 3'd1;
    localparam logic [2:0] REG_STEP_POL = 3'd2;
    localparam logic [2:0] REG_AZ_MIN   = 3'd3;
    localparam logic [2:0] REG_AZ_MAX   = 3'd4;
    localparam logic [2:0] REG_EL_MIN   = 3'd5;
    localparam logic [2:0] REG_EL_MAX   = 3'd6;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_MOVE2      = 3'd1,
        OP_MOVE3      = 3'd2,
        OP_JOG_START  = 3'd3,
        OP_STOP       = 3'd4,
        OP_CONNECT    = 3'd5,
        OP_DISCONNECT = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STEPPED  = 3'd1,
        EV_REACHED  = 3'd2,
        EV_LIMIT    = 3'd3,
        EV_STEPLIM  = 3'd4,
        EV_NOCONN   = 3'd5,
        EV_STARTED  = 3'd6,
        EV_STOPPED  = 3'd7
    } ev_t;

    typedef struct packed {
        logic [STEP_W-1:0]       step_az;
        logic [STEP_W-1:0]       step_el;
        logic [STEP_W-1:0]       step_pol;
        logic signed [POS_W-1:0] az_min;
        logic signed [POS_W-1:0] az_max;
        logic signed [POS_W-1:0] el_min;
        logic signed [POS_W-1:0] el_max;
    } cfg_t;

    typedef struct packed {
        logic [2:0]              operation;
        logic signed [POS_W-1:0] target_az;
        logic signed [POS_W-1:0] target_el;
        logic signed [POS_W-1:0] target_pol;
        logic [DIR_W-1:0]        jog_dir_az;
        logic [DIR_W-1:0]        jog_dir_el;
        logic [DIR_W-1:0]        jog_dir_pol;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_az;
        logic signed [POS_W-1:0] pos_el;
        logic signed [POS_W-1:0] pos_pol;
        logic                    moving;
        logic [2:0]              event_res;
        logic [CNT_W-1:0]        steps_taken;
    } result_t;

    typedef struct packed {
        logic                    near;
        logic signed [POS_W-1:0] approach_pos;
        logic signed [POS_W-1:0] jog_pos;
        logic                    jog_out;
    } axis_res_t;

endpackage

// ----- src/spos_axis.sv -----
module spos_axis import spos_pkg::*; (
    input  logic signed [POS_W-1:0] cur,
    input  logic signed [POS_W-1:0] goal,
    input  logic [STEP_W-1:0]       step,
    input  logic [DIR_W-1:0]        dir,
    input  logic signed [POS_W-1:0] lim_lo,
    input  logic signed [POS_W-1:0] lim_hi,
    output axis_res_t               res
);

    logic signed [POS_W:0] diff;
    logic [POS_W:0]        mag;
    logic signed [POS_W:0] step_ext;
    logic signed [POS_W:0] cur_ext;
    logic signed [POS_W:0] up_pos;
    logic signed [POS_W:0] down_pos;
    logic signed [POS_W:0] jog_pos;
    logic                  far;
    logic                  goal_above;

    always_comb begin
        cur_ext    = {cur[POS_W-1], cur};
        step_ext   = {2'b00, step};
        diff       = {goal[POS_W-1], goal} - cur_ext;
        mag        = diff[POS_W] ? (POS_W+1)'(-diff) : diff;
        far        = mag >= {2'b00, step};
        goal_above = !diff[POS_W] && (diff != '0);
        up_pos     = cur_ext + step_ext;
        down_pos   = cur_ext - step_ext;

        // Direction code 01 moves up, any code with the sign bit set moves down.
        if (dir[1]) begin
            jog_pos = down_pos;
        end else if (dir[0]) begin
            jog_pos = up_pos;
        end else begin
            jog_pos = cur_ext;
        end

        res.near = !far;
        if (far) begin
            res.approach_pos = goal_above ? up_pos[POS_W-1:0] : down_pos[POS_W-1:0];
        end else begin
            res.approach_pos = cur;
        end
        res.jog_pos = jog_pos[POS_W-1:0];
        res.jog_out = (jog_pos < $signed({lim_lo[POS_W-1], lim_lo})) ||
                      (jog_pos > $signed({lim_hi[POS_W-1], lim_hi}));
    end

endmodule

// ----- src/spos_ctrl.sv -----
module spos_ctrl import spos_pkg::*; #(
    parameter int JOG_STEP_LIMIT = 50
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_MOVE2 = 2'd1,
        MODE_MOVE3 = 2'd2,
        MODE_JOG   = 2'd3
    } mode_t;

    logic signed [POS_W-1:0] cur_az_reg, cur_el_reg, cur_pol_reg;
    logic signed [POS_W-1:0] cur_az_next, cur_el_next, cur_pol_next;
    logic signed [POS_W-1:0] goal_az_reg, goal_el_reg, goal_pol_reg;
    logic signed [POS_W-1:0] goal_az_next, goal_el_next, goal_pol_next;
    mode_t                   mode_reg, mode_next;
    logic [3*DIR_W-1:0]      dirs_reg, dirs_next;
    logic                    link_reg, link_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next, cnt_inc;
    ev_t                     ev;
    logic                    three;
    logic                    done;
    axis_res_t               ax_az, ax_el, ax_pol;

    spos_axis u_az (
        .cur    (cur_az_reg),
        .goal   (goal_az_reg),
        .step   (cfg.step_az),
        .dir    (dirs_reg[DIR_W-1:0]),
        .lim_lo (cfg.az_min),
        .lim_hi (cfg.az_max),
        .res    (ax_az)
    );

    spos_axis u_el (
        .cur    (cur_el_reg),
        .goal   (goal_el_reg),
        .step   (cfg.step_el),
        .dir    (dirs_reg[2*DIR_W-1:DIR_W]),
        .lim_lo (cfg.el_min),
        .lim_hi (cfg.el_max),
        .res    (ax_el)
    );

    spos_axis u_pol (
        .cur    (cur_pol_reg),
        .goal   (goal_pol_reg),
        .step   (cfg.step_pol),
        .dir    (dirs_reg[3*DIR_W-1:2*DIR_W]),
        .lim_lo (POL_MIN_LIMIT),
        .lim_hi (POL_MAX_LIMIT),
        .res    (ax_pol)
    );

    always_comb begin
        cur_az_next   = cur_az_reg;
        cur_el_next   = cur_el_reg;
        cur_pol_next  = cur_pol_reg;
        goal_az_next  = goal_az_reg;
        goal_el_next  = goal_el_reg;
        goal_pol_next = goal_pol_reg;
        mode_next     = mode_reg;
        dirs_next     = dirs_reg;
        link_next     = link_reg;
        cnt_next      = cnt_reg;
        ev            = EV_NONE;
        three         = (mode_reg == MODE_MOVE3);
        done          = ax_az.near && ax_el.near && (!three || ax_pol.near);
        cnt_inc       = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

        case (op_t'(item.operation))
            OP_TICK: begin
                if (mode_reg == MODE_MOVE2 || mode_reg == MODE_MOVE3) begin
                    if (done) begin
                        cur_az_next = goal_az_reg;
                        cur_el_next = goal_el_reg;
                        if (three) begin
                            cur_pol_next = goal_pol_reg;
                        end
                        mode_next = MODE_IDLE;
                        ev        = EV_REACHED;
                    end else begin
                        cur_az_next = ax_az.approach_pos;
                        cur_el_next = ax_el.approach_pos;
                        if (three) begin
                            cur_pol_next = ax_pol.approach_pos;
                        end
                        cnt_next = cnt_inc;
                        ev       = EV_STEPPED;
                    end
                end else if (mode_reg == MODE_JOG) begin
                    if (ax_az.jog_out || ax_el.jog_out || ax_pol.jog_out) begin
                        mode_next = MODE_IDLE;
                        ev        = EV_LIMIT;
                    end else begin
                        cur_az_next  = ax_az.jog_pos;
                        cur_el_next  = ax_el.jog_pos;
                        cur_pol_next = ax_pol.jog_pos;
                        cnt_next     = cnt_inc;
                        if (cnt_inc >= CNT_W'(JOG_STEP_LIMIT)) begin
                            mode_next = MODE_IDLE;
                            ev        = EV_STEPLIM;
                        end else begin
                            ev = EV_STEPPED;
                        end
                    end
                end
            end
            OP_MOVE2, OP_MOVE3: begin
                if (!link_reg) begin
                    ev = EV_NOCONN;
                end else begin
                    goal_az_next  = item.target_az;
                    goal_el_next  = item.target_el;
                    goal_pol_next = item.target_pol;
                    mode_next     = (op_t'(item.operation) == OP_MOVE2) ? MODE_MOVE2
                                                                        : MODE_MOVE3;
                    cnt_next      = '0;
                    ev            = EV_STARTED;
                end
            end
            OP_JOG_START: begin
                if (!link_reg) begin
                    ev = EV_NOCONN;
                end else if (mode_reg == MODE_IDLE) begin
                    dirs_next = {item.jog_dir_pol, item.jog_dir_el, item.jog_dir_az};
                    mode_next = MODE_JOG;
                    cnt_next  = '0;
                    ev        = EV_STARTED;
                end
            end
            OP_STOP: begin
                if (mode_reg != MODE_IDLE) begin
                    mode_next = MODE_IDLE;
                    ev        = EV_STOPPED;
                end
            end
            OP_CONNECT: begin
                link_next = 1'b1;
            end
            OP_DISCONNECT: begin
                if (link_reg) begin
                    if (mode_reg != MODE_IDLE) begin
                        mode_next = MODE_IDLE;
                        ev        = EV_STOPPED;
                    end
                    link_next = 1'b0;
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase

        res.pos_az      = cur_az_next;
        res.pos_el      = cur_el_next;
        res.pos_pol     = cur_pol_next;
        res.moving      = (mode_next != MODE_IDLE);
        res.event_res   = ev;
        res.steps_taken = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_az_reg   <= '0;
            cur_el_reg   <= '0;
            cur_pol_reg  <= '0;
            goal_az_reg  <= '0;
            goal_el_reg  <= '0;
            goal_pol_reg <= '0;
            mode_reg     <= MODE_IDLE;
            dirs_reg     <= '0;
            link_reg     <= 1'b0;
            cnt_reg      <= '0;
        end else if (advance) begin
            cur_az_reg   <= cur_az_next;
            cur_el_reg   <= cur_el_next;
            cur_pol_reg  <= cur_pol_next;
            goal_az_reg  <= goal_az_next;
            goal_el_reg  <= goal_el_next;
            goal_pol_reg <= goal_pol_next;
            mode_reg     <= mode_next;
            dirs_reg     <= dirs_next;
            link_reg     <= link_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

// ----- src/three_axis_step_positioner_core.sv -----
// An accepted request waits in the input register until the result register is free,
// whose value drives m_tdata. Throughput: one request per cycle while m_tready is high;
// the two registers let a new request enter while a finished result waits on m_tready.
// Reset (aresetn, synchronous, active low) clears positions, targets, motion
// state, link and step counter, and loads the step and limit registers with defaults.
module three_axis_step_positioner_core import spos_pkg::*; #(
    parameter int JOG_STEP_LIMIT = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // target_az, target_el, target_pol, jog_dir_az, jog_dir_el, jog_dir_pol, zero pad
    input  logic [63:0] s_tdata,
    // operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pos_az, pos_el, pos_pol, moving, event_res, steps_taken, zero pad
    output logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    m_tvalid_reg;
    logic    advance;

    assign advance  = item_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg.steps_taken, res_reg.event_res, res_reg.moving,
                       res_reg.pos_pol, res_reg.pos_el, res_reg.pos_az};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_az  <= STEP_RESET;
            cfg_reg.step_el  <= STEP_RESET;
            cfg_reg.step_pol <= STEP_RESET;
            cfg_reg.az_min   <= AZ_MIN_RESET;
            cfg_reg.az_max   <= AZ_MAX_RESET;
            cfg_reg.el_min   <= EL_MIN_RESET;
            cfg_reg.el_max   <= EL_MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STEP_AZ:  cfg_reg.step_az  <= cfg_data[STEP_W-1:0];
                REG_STEP_EL:  cfg_reg.step_el  <= cfg_data[STEP_W-1:0];
                REG_STEP_POL: cfg_reg.step_pol <= cfg_data[STEP_W-1:0];
                REG_AZ_MIN:   cfg_reg.az_min   <= cfg_data;
                REG_AZ_MAX:   cfg_reg.az_max   <= cfg_data;
                REG_EL_MIN:   cfg_reg.el_min   <= cfg_data;
                REG_EL_MAX:   cfg_reg.el_max   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg.operation   <= s_tuser;
            item_reg.target_az   <= s_tdata[16:0];
            item_reg.target_el   <= s_tdata[33:17];
            item_reg.target_pol  <= s_tdata[50:34];
            item_reg.jog_dir_az  <= s_tdata[52:51];
            item_reg.jog_dir_el  <= s_tdata[54:53];
            item_reg.jog_dir_pol <= s_tdata[56:55];
        end
    end

    spos_ctrl #(
        .JOG_STEP_LIMIT (JOG_STEP_LIMIT)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- src/spos_checker.sv -----
module spos_checker import spos_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic [2:0]       ev;
    logic             moving;
    logic [CNT_W-1:0] steps;

    assign ev     = m_tdata[54:52];
    assign moving = m_tdata[51];
    assign steps  = m_tdata[70:55];

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_started: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ev == EV_STARTED |-> moving && steps == '0)
        else $error("started result without motion or with a stale count");

    a_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ev == EV_REACHED || ev == EV_LIMIT || ev == EV_STEPLIM ||
                     ev == EV_STOPPED) |-> !moving)
        else $error("motion reported as ended but still moving");

    a_stepped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ev == EV_STEPPED |-> moving && steps != '0)
        else $error("step reported outside of motion");

endmodule

bind three_axis_step_positioner_core spos_checker u_spos_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/three_axis_step_positioner_core_test.sv -----
`timescale 1ns / 100ps

module three_axis_step_positioner_core_test;
    import spos_pkg::*;

    localparam int JOG_STEPS   = 50;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int COORD_MAX   = 36000;

    typedef enum int {MOTION_IDLE, MOTION_MOVE2, MOTION_MOVE3, MOTION_JOG} motion_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    three_axis_step_positioner_core #(.JOG_STEP_LIMIT(JOG_STEPS)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Positioner state as the block should hold it; axis 0 az, 1 el, 2 pol.
    int      pos_now[3]   = '{0, 0, 0};
    int      goal_now[3]  = '{0, 0, 0};
    int      jog_dir[3]   = '{0, 0, 0};
    motion_t motion       = MOTION_IDLE;
    bit      linked       = 1'b0;
    int      step_count   = 0;
    int      step_size[3] = '{100, 100, 100};
    int      lim_lo[3]    = '{int'(AZ_MIN_RESET), int'(EL_MIN_RESET), int'(POL_MIN_LIMIT)};
    int      lim_hi[3]    = '{int'(AZ_MAX_RESET), int'(EL_MAX_RESET), int'(POL_MAX_LIMIT)};

    result_t status_due[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  requests_sent = 0;
    int  results_checked = 0;
    int  settings_used = 0;
    int  ev_seen[8] = '{default: 0};
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;
    int  stall_pct = 0;
    int  stall_run = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     status_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        bit ready_now;
        if (stall_run > 0) begin
            stall_run--;
            ready_now = 1'b0;
        end else if (stall_pct == 0) begin
            ready_now = 1'b1;
        end else begin
            if ($urandom_range(0, 49) == 0)
                stall_run = $urandom_range(5, 25);
            ready_now = $urandom_range(1, 100) > stall_pct;
        end
        m_tready <= ready_now;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 20)
            $display("Mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (status_due.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata[54:52], -1);
            end else begin
                want = status_due.pop_front();
                if (m_tdata[16:0] != want.pos_az)
                    report_mismatch("pos_az", $signed(m_tdata[16:0]), want.pos_az);
                if (m_tdata[33:17] != want.pos_el)
                    report_mismatch("pos_el", $signed(m_tdata[33:17]), want.pos_el);
                if (m_tdata[50:34] != want.pos_pol)
                    report_mismatch("pos_pol", $signed(m_tdata[50:34]), want.pos_pol);
                if (m_tdata[51] != want.moving)
                    report_mismatch("moving", m_tdata[51], want.moving);
                if (m_tdata[54:52] != want.event_res)
                    report_mismatch("event_res", m_tdata[54:52], want.event_res);
                if (m_tdata[70:55] != want.steps_taken)
                    report_mismatch("steps_taken", m_tdata[70:55], want.steps_taken);
            end
        end
    end

    function automatic result_t step_positioner(input logic [2:0] op, input int taz,
                                                input int tel, input int tpol,
                                                input logic [1:0] dir_az,
                                                input logic [1:0] dir_el,
                                                input logic [1:0] dir_pol);
        int         d;
        int         nxt[3];
        bit         done;
        bit         out_of_range;
        bit         three;
        ev_t        ev;
        result_t    r;
        logic [1:0] dirs[3];
        ev = EV_NONE;
        dirs[0] = dir_az;
        dirs[1] = dir_el;
        dirs[2] = dir_pol;
        case (op)
            OP_TICK: begin
                if (motion == MOTION_MOVE2 || motion == MOTION_MOVE3) begin
                    three = (motion == MOTION_MOVE3);
                    done = 1'b1;
                    for (int a = 0; a < 3; a++) begin
                        d = goal_now[a] - pos_now[a];
                        if ((a < 2 || three) && (d < 0 ? -d : d) >= step_size[a])
                            done = 1'b0;
                    end
                    if (done) begin
                        for (int a = 0; a < 3; a++)
                            if (a < 2 || three)
                                pos_now[a] = goal_now[a];
                        motion = MOTION_IDLE;
                        ev = EV_REACHED;
                    end else begin
                        for (int a = 0; a < 3; a++) begin
                            d = goal_now[a] - pos_now[a];
                            if ((a < 2 || three) && (d < 0 ? -d : d) >= step_size[a])
                                pos_now[a] += (d > 0) ? step_size[a] : -step_size[a];
                        end
                        if (step_count < 65535)
                            step_count++;
                        ev = EV_STEPPED;
                    end
                end else if (motion == MOTION_JOG) begin
                    out_of_range = 1'b0;
                    for (int a = 0; a < 3; a++) begin
                        nxt[a] = pos_now[a] + jog_dir[a] * step_size[a];
                        if (nxt[a] < lim_lo[a] || nxt[a] > lim_hi[a])
                            out_of_range = 1'b1;
                    end
                    if (out_of_range) begin
                        motion = MOTION_IDLE;
                        ev = EV_LIMIT;
                    end else begin
                        pos_now = nxt;
                        if (step_count < 65535)
                            step_count++;
                        if (step_count >= JOG_STEPS) begin
                            motion = MOTION_IDLE;
                            ev = EV_STEPLIM;
                        end else begin
                            ev = EV_STEPPED;
                        end
                    end
                end
            end
            OP_MOVE2, OP_MOVE3: begin
                if (!linked) begin
                    ev = EV_NOCONN;
                end else begin
                    goal_now[0] = taz;
                    goal_now[1] = tel;
                    goal_now[2] = tpol;
                    motion = (op == OP_MOVE2) ? MOTION_MOVE2 : MOTION_MOVE3;
                    step_count = 0;
                    ev = EV_STARTED;
                end
            end
            OP_JOG_START: begin
                if (!linked) begin
                    ev = EV_NOCONN;
                end else if (motion == MOTION_IDLE) begin
                    // The pattern 2'b10 saturates to a downward direction.
                    for (int a = 0; a < 3; a++)
                        jog_dir[a] = (dirs[a] == 2'b01) ? 1 : (dirs[a][1] ? -1 : 0);
                    motion = MOTION_JOG;
                    step_count = 0;
                    ev = EV_STARTED;
                end
            end
            OP_STOP: begin
                if (motion != MOTION_IDLE) begin
                    motion = MOTION_IDLE;
                    ev = EV_STOPPED;
                end
            end
            OP_CONNECT: begin
                linked = 1'b1;
            end
            OP_DISCONNECT: begin
                if (linked) begin
                    if (motion != MOTION_IDLE) begin
                        motion = MOTION_IDLE;
                        ev = EV_STOPPED;
                    end
                    linked = 1'b0;
                end
            end
            default: begin
            end
        endcase
        ev_seen[ev]++;
        r.pos_az      = POS_W'(pos_now[0]);
        r.pos_el      = POS_W'(pos_now[1]);
        r.pos_pol     = POS_W'(pos_now[2]);
        r.moving      = (motion != MOTION_IDLE);
        r.event_res   = ev;
        r.steps_taken = step_count[15:0];
        return r;
    endfunction

    task automatic send_request(input logic [2:0] op, input int taz, input int tel,
                                input int tpol, input logic [1:0] dir_az,
                                input logic [1:0] dir_el, input logic [1:0] dir_pol);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, dir_pol, dir_el, dir_az, tpol[16:0], tel[16:0], taz[16:0]};
        do @(posedge aclk); while (!s_tready);
        status_due.insert(status_due.size(),
                          step_positioner(op, taz, tel, tpol, dir_az, dir_el, dir_pol));
        requests_sent++;
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
    endfunction

    task automatic send_op(input logic [2:0] op);
        send_request(op, rand_coord(), rand_coord(), rand_coord(), 2'($urandom),
                     2'($urandom), 2'($urandom));
    endtask

    function automatic int pick_target(input int a);
        int span;
        int t;
        if ($urandom_range(0, 3) == 0)
            return rand_coord();
        span = (step_size[a] > 3000) ? 3000 : step_size[a] + 1;
        t = pos_now[a] + int'($urandom_range(0, 12 * span)) - 6 * span;
        if (t > COORD_MAX)
            t = COORD_MAX;
        if (t < -COORD_MAX)
            t = -COORD_MAX;
        return t;
    endfunction

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    task automatic apply_settings(input int s_az, input int s_el, input int s_pol,
                                  input int az_lo, input int az_hi,
                                  input int el_lo, input int el_hi);
        logic [2:0] reg_ids[7];
        int         vals[7];
        reg_ids = '{REG_STEP_AZ, REG_STEP_EL, REG_STEP_POL, REG_AZ_MIN, REG_AZ_MAX,
                    REG_EL_MIN, REG_EL_MAX};
        vals = '{s_az, s_el, s_pol, az_lo, az_hi, el_lo, el_hi};
        wait_results_done();
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data  <= vals[i][16:0];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        step_size[0] = vals[0] & 32'hFFFF;
        step_size[1] = vals[1] & 32'hFFFF;
        step_size[2] = vals[2] & 32'hFFFF;
        lim_lo[0] = int'($signed(vals[3][16:0]));
        lim_hi[0] = int'($signed(vals[4][16:0]));
        lim_lo[1] = int'($signed(vals[5][16:0]));
        lim_hi[1] = int'($signed(vals[6][16:0]));
        settings_used++;
    endtask

    task automatic test_directed_commands();
        sender_gaps = 1'b1;
        stall_pct = 30;
        send_request(OP_TICK, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_MOVE2, 500, 500, 500, 2'b00, 2'b00, 2'b00);
        send_request(OP_JOG_START, 0, 0, 0, 2'b01, 2'b01, 2'b01);
        send_request(OP_STOP, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_DISCONNECT, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(3'b111, -COORD_MAX, COORD_MAX, -1, 2'b11, 2'b10, 2'b01);
        send_request(OP_CONNECT, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_CONNECT, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        // Polarization target is ignored by a two-axis move.
        send_request(OP_MOVE2, 250, -150, COORD_MAX, 2'b00, 2'b00, 2'b00);
        repeat (3) send_request(OP_TICK, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_MOVE3, COORD_MAX, -COORD_MAX, -COORD_MAX, 2'b00, 2'b00, 2'b00);
        send_request(OP_TICK, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_MOVE3, -COORD_MAX, COORD_MAX, COORD_MAX, 2'b00, 2'b00, 2'b00);
        send_request(OP_JOG_START, 0, 0, 0, 2'b01, 2'b01, 2'b01);
        send_request(OP_TICK, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_STOP, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_STOP, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_JOG_START, 0, 0, 0, 2'b10, 2'b01, 2'b11);
        repeat (2) send_request(OP_TICK, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_DISCONNECT, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_TICK, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_request(OP_CONNECT, 0, 0, 0, 2'b00, 2'b00, 2'b00);
    endtask

    task automatic test_special_settings();
        // A slow jog runs into the step limit well inside its travel range.
        apply_settings(1, 1, 1, int'(AZ_MIN_RESET), int'(AZ_MAX_RESET),
                       int'(EL_MIN_RESET), int'(EL_MAX_RESET));
        send_request(OP_JOG_START, 0, 0, 0, 2'b01, 2'b00, 2'b11);
        repeat (JOG_STEPS + 3) send_op(OP_TICK);
        // Full-size steps leave the fixed polarization range at once.
        apply_settings(36000, 36000, 36000, -COORD_MAX, COORD_MAX, -COORD_MAX, COORD_MAX);
        send_request(OP_JOG_START, 0, 0, 0, 2'b01, 2'b01, 2'b01);
        send_op(OP_TICK);
        send_request(OP_JOG_START, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        repeat (3) send_op(OP_TICK);
        send_op(OP_STOP);
        // With each minimum above its maximum every jog tick is a limit hit.
        apply_settings(100, 100, 100, 500, -500, 500, -500);
        send_request(OP_JOG_START, 0, 0, 0, 2'b00, 2'b00, 2'b00);
        send_op(OP_TICK);
        // A zero step never counts as close enough and holds a jogging axis.
        apply_settings(0, 100, 0, int'(AZ_MIN_RESET), int'(AZ_MAX_RESET),
                       int'(EL_MIN_RESET), int'(EL_MAX_RESET));
        send_request(OP_MOVE3, pos_now[0] + 40, pos_now[1] - 230, pos_now[2] + 7,
                     2'b00, 2'b00, 2'b00);
        repeat (6) send_op(OP_TICK);
        send_op(OP_STOP);
        send_request(OP_JOG_START, 0, 0, 0, 2'b01, 2'b00, 2'b10);
        repeat (4) send_op(OP_TICK);
        send_op(OP_STOP);
    endtask

    task automatic run_traffic(input int count);
        int sent;
        int pick;
        int n;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (!linked && $urandom_range(0, 4) != 0) begin
                send_op(OP_CONNECT);
                sent++;
            end else if (pick < 40) begin
                send_request($urandom_range(0, 1) ? OP_MOVE3 : OP_MOVE2, pick_target(0),
                             pick_target(1), pick_target(2), 2'($urandom), 2'($urandom),
                             2'($urandom));
                n = $urandom_range(0, 14);
                repeat (n) send_op(OP_TICK);
                sent += n + 1;
            end else if (pick < 75) begin
                send_op(OP_JOG_START);
                n = $urandom_range(0, JOG_STEPS + 10);
                repeat (n) send_op(OP_TICK);
                sent += n + 1;
            end else begin
                send_op(3'($urandom_range(0, 7)));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int a0;
        int a1;
        int e0;
        int e1;
        for (int ph = 0; ph < 6; ph++) begin
            a0 = rand_coord();
            a1 = rand_coord();
            e0 = rand_coord();
            e1 = rand_coord();
            case (ph)
                0: apply_settings(100, 100, 100, int'(AZ_MIN_RESET), int'(AZ_MAX_RESET),
                                  int'(EL_MIN_RESET), int'(EL_MAX_RESET));
                1: apply_settings(1, 36000, 1, -COORD_MAX, COORD_MAX, -COORD_MAX, COORD_MAX);
                2: apply_settings(36000, 1, 36000, COORD_MAX, -COORD_MAX, COORD_MAX,
                                  -COORD_MAX);
                3: apply_settings(7, 13, 250, -500, 500, -300, 300);
                4: apply_settings($urandom_range(1, 36000), $urandom_range(1, 36000),
                                  $urandom_range(1, 36000), (a0 < a1) ? a0 : a1,
                                  (a0 < a1) ? a1 : a0, (e0 < e1) ? e0 : e1,
                                  (e0 < e1) ? e1 : e0);
                default: apply_settings($urandom_range(1, 400), $urandom_range(1, 400),
                                        $urandom_range(1, 400), (a0 < a1) ? a0 : a1,
                                        (a0 < a1) ? a1 : a0, e0, e1);
            endcase
            sender_gaps = (ph % 2 == 0);
            stall_pct = (ph == 2) ? 70 : (ph == 4) ? 50 : (ph == 1 || ph == 3) ? 0 : 30;
            run_traffic(150);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_special_settings();
        test_random_traffic();
        wait_results_done();
        repeat (8) @(posedge aclk);
        if (status_due.size() != 0)
            report_mismatch("requests left without a result", status_due.size(), 0);
        $display("Ran %0d requests under %0d register settings and checked %0d results.",
                 requests_sent, settings_used, results_checked);
        $display("Targets reached %0d, limit hits %0d, step limits %0d, refused %0d.",
                 ev_seen[EV_REACHED], ev_seen[EV_LIMIT], ev_seen[EV_STEPLIM],
                 ev_seen[EV_NOCONN]);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
